@@ rtl/core/ipv4tf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4tf_pkg
// shared types and codes of the ipv4 tcp encapsulation and filter block
// ----------------------------------------------------------------------------
package ipv4tf_pkg;

    localparam int QUEUE_DEPTH = 4;

    // queue entry kinds
    localparam logic [1:0] KIND_RX     = 2'd0;
    localparam logic [1:0] KIND_TX     = 2'd1;
    localparam logic [1:0] KIND_TX_HDR = 2'd2;

    // receive packet status
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_DROP     = 2'd1;
    localparam logic [1:0] STATUS_HDR_LONG = 2'd2;

    // tcp checksum byte substitution
    localparam logic [1:0] REPL_NONE = 2'd0;
    localparam logic [1:0] REPL_HI   = 2'd1;
    localparam logic [1:0] REPL_LO   = 2'd2;

    localparam logic [4:0] HDR_BYTES    = 5'd20;
    localparam logic [7:0] PROTO_TCP    = 8'h06;
    localparam logic [3:0] MIN_IHL      = 4'h5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic        valid;
        logic        last;
        logic [1:0]  status;
        logic [1:0]  repl;
        logic [15:0] seg_len;
        logic [15:0] partial;
        logic [31:0] peer;
    } entry_t;

endpackage
`default_nettype wire

@@ rtl/core/ipv4tf_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4tf_front
// accepts input bytes, runs receive filtering and transmit position tracking,
// and queues one request per produced result group
// ----------------------------------------------------------------------------
module ipv4tf_front (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire  [39:0]            s_axis_tdata,  // in_byte, segment_length, tcp_partial_sum
    input  wire                    s_axis_tlast,
    input  wire                    s_axis_tuser,  // command
    input  wire  [31:0]            local_address,
    output logic                   q_push,
    output ipv4tf_pkg::entry_t     q_data,
    input  wire                    q_full
);
    import ipv4tf_pkg::*;

    logic [31:0] peer_address_reg,     peer_address_next;
    logic [31:0] captured_source_reg,  captured_source_next;
    logic [15:0] rx_pos_reg,           rx_pos_next;
    logic [5:0]  rx_hdr_bytes_reg,     rx_hdr_bytes_next;
    logic        rx_match_reg,         rx_match_next;
    logic [15:0] tx_pos_reg,           tx_pos_next;

    logic        accept;
    logic [7:0]  b;
    logic [15:0] seg_len;
    logic [15:0] partial;
    logic [7:0]  want;
    logic        match_now;
    logic [5:0]  hdr_now;
    logic [16:0] pos_inc;
    logic        rx_payload;
    logic [1:0]  rx_status;

    assign accept        = s_axis_tvalid && !q_full;
    assign s_axis_tready = !q_full;
    assign b             = s_axis_tdata[7:0];
    assign seg_len       = s_axis_tdata[23:8];
    assign partial       = s_axis_tdata[39:24];
    assign pos_inc       = {1'b0, rx_pos_reg} + 17'd1;

    always_comb
    begin
        case (rx_pos_reg[1:0])
            2'd0:    want = local_address[31:24];
            2'd1:    want = local_address[23:16];
            2'd2:    want = local_address[15:8];
            default: want = local_address[7:0];
        endcase
    end

    always_comb
    begin
        match_now = rx_match_reg;
        hdr_now   = rx_hdr_bytes_reg;
        if (rx_pos_reg == 16'd0)
        begin
            hdr_now = {b[3:0], 2'b00};
            if (b[3:0] < MIN_IHL)
                match_now = 1'b0;
        end
        if (rx_pos_reg == 16'd9 && b != PROTO_TCP)
            match_now = 1'b0;
        if (rx_pos_reg >= 16'd16 && rx_pos_reg <= 16'd19 && b != want)
            match_now = 1'b0;
    end

    assign rx_payload = match_now && rx_pos_reg >= 16'd20 && rx_pos_reg >= {10'd0, hdr_now};

    always_comb
    begin
        if (rx_pos_reg < 16'd19 || !match_now)
            rx_status = STATUS_DROP;
        else if (pos_inc < {11'd0, hdr_now})
            rx_status = STATUS_HDR_LONG;
        else
            rx_status = STATUS_OK;
    end

    always_comb
    begin
        peer_address_next    = peer_address_reg;
        captured_source_next = captured_source_reg;
        rx_pos_next          = rx_pos_reg;
        rx_hdr_bytes_next    = rx_hdr_bytes_reg;
        rx_match_next        = rx_match_reg;
        tx_pos_next          = tx_pos_reg;
        q_push               = 1'b0;
        q_data               = '0;
        q_data.seg_len       = seg_len;
        q_data.partial       = partial;
        q_data.peer          = peer_address_reg;
        q_data.last          = s_axis_tlast;

        if (accept && !s_axis_tuser)
        begin
            // receive path
            rx_hdr_bytes_next = hdr_now;
            rx_match_next     = match_now;
            if (rx_pos_reg >= 16'd12 && rx_pos_reg <= 16'd15)
                captured_source_next = {captured_source_reg[23:0], b};
            if (match_now && rx_pos_reg >= 16'd19 && pos_inc == {11'd0, hdr_now})
                peer_address_next = captured_source_reg;

            q_data.kind = KIND_RX;
            if (rx_payload)
            begin
                q_push       = 1'b1;
                q_data.data  = b;
                q_data.valid = 1'b1;
            end
            else if (s_axis_tlast)
            begin
                q_push        = 1'b1;
                q_data.status = rx_status;
            end

            if (s_axis_tlast)
            begin
                rx_pos_next       = 16'd0;
                rx_hdr_bytes_next = 6'd0;
                rx_match_next     = 1'b1;
            end
            else if (rx_pos_reg != 16'hFFFF)
                rx_pos_next = rx_pos_reg + 16'd1;
        end
        else if (accept)
        begin
            // transmit path
            q_push       = 1'b1;
            q_data.data  = b;
            q_data.valid = 1'b1;
            q_data.kind  = (tx_pos_reg == 16'd0) ? KIND_TX_HDR : KIND_TX;
            if (tx_pos_reg == 16'd16)
                q_data.repl = REPL_HI;
            else if (tx_pos_reg == 16'd17)
                q_data.repl = REPL_LO;
            else
                q_data.repl = REPL_NONE;

            if (s_axis_tlast)
                tx_pos_next = 16'd0;
            else if (tx_pos_reg != 16'hFFFF)
                tx_pos_next = tx_pos_reg + 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peer_address_reg    <= '0;
            captured_source_reg <= '0;
            rx_pos_reg          <= '0;
            rx_hdr_bytes_reg    <= '0;
            rx_match_reg        <= 1'b1;
            tx_pos_reg          <= '0;
        end
        else
        begin
            peer_address_reg    <= peer_address_next;
            captured_source_reg <= captured_source_next;
            rx_pos_reg          <= rx_pos_next;
            rx_hdr_bytes_reg    <= rx_hdr_bytes_next;
            rx_match_reg        <= rx_match_next;
            tx_pos_reg          <= tx_pos_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/ipv4tf_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4tf_queue
// short request queue between the front and back parts
// ----------------------------------------------------------------------------
module ipv4tf_queue #(
    parameter int DEPTH = ipv4tf_pkg::QUEUE_DEPTH
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    push,
    input  wire ipv4tf_pkg::entry_t push_data,
    output logic                   full,
    input  wire                    pop,
    output ipv4tf_pkg::entry_t     head,
    output logic                   head_valid
);
    import ipv4tf_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    entry_t        entries_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;
    logic          do_push;
    logic          do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/ipv4tf_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4tf_back
// expands queued requests into output bytes: header generation with running
// checksums, tcp checksum substitution and receive status results
// ----------------------------------------------------------------------------
module ipv4tf_back (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    q_valid,
    input  wire ipv4tf_pkg::entry_t q_data,
    output logic                   q_pop,
    input  wire  [31:0]            local_address,
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    output logic [15:0]            m_axis_tdata,  // out_byte, packet_status
    output logic                   m_axis_tlast,
    output logic [1:0]             m_axis_tuser   // out_path, byte_valid
);
    import ipv4tf_pkg::*;

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] c);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, c};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    function automatic logic [15:0] hdr_word(
        input logic [3:0]  idx,
        input logic [15:0] total,
        input logic [31:0] src,
        input logic [31:0] dst,
        input logic [15:0] csum
    );
        logic [15:0] w;
        case (idx)
            4'd0:    w = 16'h4500;
            4'd1:    w = total;
            4'd3:    w = 16'h4000;
            4'd4:    w = {8'hFF, PROTO_TCP};
            4'd5:    w = csum;
            4'd6:    w = src[31:16];
            4'd7:    w = src[15:0];
            4'd8:    w = dst[31:16];
            4'd9:    w = dst[15:0];
            default: w = 16'h0000;
        endcase
        return w;
    endfunction

    logic        out_valid_reg, out_valid_next;
    logic        out_path_reg,  out_path_next;
    logic [7:0]  out_byte_reg,  out_byte_next;
    logic        out_bv_reg,    out_bv_next;
    logic        out_last_reg,  out_last_next;
    logic [1:0]  out_stat_reg,  out_stat_next;
    logic [4:0]  hdr_cnt_reg,   hdr_cnt_next;
    logic [15:0] hsum_reg,      hsum_next;
    logic [15:0] tacc_reg,      tacc_next;

    logic        adv;
    logic [15:0] total;
    logic [15:0] byte_word;
    logic [15:0] sum_word;
    logic [15:0] seg_csum;
    logic [15:0] tcp_term;

    assign adv      = !out_valid_reg || m_axis_tready;
    assign total    = q_data.seg_len + 16'd20;
    assign seg_csum = ~tacc_reg;

    assign byte_word = hdr_word(hdr_cnt_reg[4:1], total, local_address, q_data.peer, ~hsum_reg);
    assign sum_word  = hdr_word(hdr_cnt_reg[3:0], total, local_address, q_data.peer, 16'h0000);

    always_comb
    begin
        case (hdr_cnt_reg)
            5'd1:    tcp_term = local_address[15:0];
            5'd2:    tcp_term = q_data.peer[31:16];
            5'd3:    tcp_term = q_data.peer[15:0];
            5'd4:    tcp_term = {8'd0, PROTO_TCP};
            default: tcp_term = q_data.seg_len;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_path_next  = out_path_reg;
        out_byte_next  = out_byte_reg;
        out_bv_next    = out_bv_reg;
        out_last_next  = out_last_reg;
        out_stat_next  = out_stat_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        hsum_next      = hsum_reg;
        tacc_next      = tacc_reg;
        q_pop          = 1'b0;

        if (adv)
        begin
            out_valid_next = q_valid;
            if (q_valid)
            begin
                case (q_data.kind)
                    KIND_RX:
                    begin
                        out_path_next = 1'b0;
                        out_byte_next = q_data.data;
                        out_bv_next   = q_data.valid;
                        out_last_next = q_data.last;
                        out_stat_next = q_data.status;
                        q_pop         = 1'b1;
                    end
                    KIND_TX:
                    begin
                        out_path_next = 1'b1;
                        out_bv_next   = 1'b1;
                        out_last_next = q_data.last;
                        out_stat_next = STATUS_OK;
                        case (q_data.repl)
                            REPL_HI: out_byte_next = seg_csum[15:8];
                            REPL_LO: out_byte_next = seg_csum[7:0];
                            default: out_byte_next = q_data.data;
                        endcase
                        q_pop = 1'b1;
                    end
                    KIND_TX_HDR:
                    begin
                        out_path_next = 1'b1;
                        out_bv_next   = 1'b1;
                        out_stat_next = STATUS_OK;
                        if (hdr_cnt_reg == HDR_BYTES)
                        begin
                            out_byte_next = q_data.data;
                            out_last_next = q_data.last;
                            hdr_cnt_next  = 5'd0;
                            q_pop         = 1'b1;
                        end
                        else
                        begin
                            out_byte_next = hdr_cnt_reg[0] ? byte_word[7:0] : byte_word[15:8];
                            out_last_next = 1'b0;
                            hdr_cnt_next  = hdr_cnt_reg + 5'd1;
                            // header checksum, one word per byte slot
                            if (hdr_cnt_reg == 5'd0)
                                hsum_next = oc_add(16'h0000, sum_word);
                            else if (hdr_cnt_reg < 5'd10)
                                hsum_next = oc_add(hsum_reg, sum_word);
                            // tcp pseudo-header completion
                            if (hdr_cnt_reg == 5'd0)
                                tacc_next = oc_add(q_data.partial, local_address[31:16]);
                            else if (hdr_cnt_reg < 5'd6)
                                tacc_next = oc_add(tacc_reg, tcp_term);
                        end
                    end
                    default:
                    begin
                        out_valid_next = 1'b0;
                        q_pop          = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            hdr_cnt_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            hdr_cnt_reg   <= hdr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_path_reg <= out_path_next;
        out_byte_reg <= out_byte_next;
        out_bv_reg   <= out_bv_next;
        out_last_reg <= out_last_next;
        out_stat_reg <= out_stat_next;
        hsum_reg     <= hsum_next;
        tacc_reg     <= tacc_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_stat_reg, out_byte_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = {out_bv_reg, out_path_reg};

`ifndef NO_ASSERTIONS
    a_hdr_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_cnt_reg <= HDR_BYTES)
        else $error("header counter out of range");

    a_hdr_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (hdr_cnt_reg != 5'd0 && adv) |=>
            (hdr_cnt_reg == $past(hdr_cnt_reg) + 5'd1 || hdr_cnt_reg == 5'd0))
        else $error("header counter skipped");

    a_hdr_holds_head: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_cnt_reg != 5'd0 |-> (q_valid && q_data.kind == KIND_TX_HDR))
        else $error("header burst lost its request");

    a_status_rx_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_stat_reg != STATUS_OK || !out_bv_reg)) |->
            (!out_path_reg && out_last_reg))
        else $error("status result outside receive frame end");
`endif

endmodule
`default_nettype wire

@@ rtl/core/ipv4_tcp_encap_and_filter_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_tcp_encap_and_filter_top
// ipv4 layer for tcp over byte streams: header insertion on transmit,
// header check and strip on receive
// ----------------------------------------------------------------------------
// one byte is accepted per cycle while the request queue has room. a receive
// byte or a later segment byte gives at most one output byte, so those run at
// one byte per cycle while the output is ready, as the back end sends one byte
// per cycle through its output register; the first byte of a transmit segment
// gives 21 output bytes (the 20-byte header and the byte itself). the queue of
// QUEUE_DEPTH requests soaks up input meanwhile. an accepted input byte is
// written into the request queue and then into the back end's output register
// before it is presented. local_address is written through cfg_wr_en and
// cfg_wr_data and should only change while the block is idle.
module ipv4_tcp_encap_and_filter_top #(
    parameter int QUEUE_DEPTH = ipv4tf_pkg::QUEUE_DEPTH
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_wr_en,
    input  wire  [31:0] cfg_wr_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [39:0] s_axis_tdata,  // in_byte, segment_length, tcp_partial_sum
    input  wire         s_axis_tlast,  // in_last
    input  wire         s_axis_tuser,  // command
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,  // out_byte, packet_status
    output logic        m_axis_tlast,  // out_last
    output logic [1:0]  m_axis_tuser   // out_path, byte_valid
);
    import ipv4tf_pkg::*;

    logic [31:0] local_address_reg;
    logic        q_push;
    entry_t      q_wdata;
    logic        q_full;
    logic        q_pop;
    entry_t      q_head;
    logic        q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            local_address_reg <= '0;
        else if (cfg_wr_en)
            local_address_reg <= cfg_wr_data;
    end

    ipv4tf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .local_address (local_address_reg),
        .q_push        (q_push),
        .q_data        (q_wdata),
        .q_full        (q_full)
    );

    ipv4tf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_wdata),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .head_valid (q_valid)
    );

    ipv4tf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_data        (q_head),
        .q_pop         (q_pop),
        .local_address (local_address_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
`default_nettype wire

@@ dv/tb_ipv4_tcp_encap_and_filter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ipv4_tcp_encap_and_filter_top
// self-checking bench for the ipv4 tcp encapsulation and filter block: an
// in-bench model of both paths predicts every output byte from the accepted
// requests, and a scoreboard compares each output byte field by field, under
// random stalls on both streams and several local address settings
// ----------------------------------------------------------------------------
module tb_ipv4_tcp_encap_and_filter_top;

    import ipv4tf_pkg::*;

    localparam bit        CMD_RX         = 1'b0;
    localparam bit        CMD_TX         = 1'b1;
    localparam bit        PATH_RX        = 1'b0;
    localparam bit        PATH_TX        = 1'b1;
    localparam bit [7:0]  VER_IHL        = 8'h45;
    localparam bit [7:0]  FLAGS_DF_HI    = 8'h40;
    localparam bit [7:0]  TTL_MAX        = 8'hFF;
    localparam bit [15:0] POS_MAX        = 16'hFFFF;
    localparam int        SETTLE_CYCLES  = 100;
    localparam int        WATCHDOG_LIMIT = 4000;

    typedef struct {
        bit        cmd;
        bit [7:0]  data;
        bit        is_last;
        bit [15:0] seg_len;
        bit [15:0] partial;
    } seg_req_t;

    typedef struct {
        bit       path;
        bit [7:0] data;
        bit       vld;
        bit       is_last;
        bit [1:0] status;
    } frame_byte_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [31:0] cfg_wr_data   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;  // in_byte, segment_length, tcp_partial_sum
    logic        s_axis_tlast  = 1'b0;  // in_last
    logic        s_axis_tuser  = 1'b0;  // command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;  // out_byte, packet_status
    logic        m_axis_tlast;  // out_last
    logic [1:0]  m_axis_tuser;  // out_path, byte_valid

    // model state
    bit [31:0] local_addr;
    bit [31:0] peer_addr;
    bit [31:0] src_capture;
    bit [15:0] rx_pos;
    bit [5:0]  rx_hdr_len;
    bit        rx_match;
    bit [15:0] tx_pos;
    bit [15:0] tx_csum;

    frame_byte_t expected_bytes[$];
    seg_req_t    rx_pkt[$];
    seg_req_t    tx_seg[$];
    int          fail_count   = 0;
    int          sent_items   = 0;
    int          stall_cycles = 0;
    bit          no_idle      = 1'b0;

    ipv4_tcp_encap_and_filter_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic bit [15:0] csum_add(input bit [15:0] a, input bit [15:0] b);
        bit [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    function automatic void queue_result(input bit path, input bit [7:0] data, input bit vld,
                                         input bit is_last, input bit [1:0] status);
        frame_byte_t e;
        e.path    = path;
        e.data    = data;
        e.vld     = vld;
        e.is_last = is_last;
        e.status  = status;
        expected_bytes.push_back(e);
    endfunction

    function automatic void reset_model();
        local_addr  = '0;
        peer_addr   = '0;
        src_capture = '0;
        rx_pos      = '0;
        rx_hdr_len  = '0;
        rx_match    = 1'b1;
        tx_pos      = '0;
        tx_csum     = '0;
    endfunction

    function automatic void predict_outputs(input seg_req_t r);
        bit [7:0]  hdr[20];
        bit [15:0] total;
        bit [15:0] sum;
        bit [7:0]  ob;
        bit [1:0]  status;
        int        idx;
        if (r.cmd == CMD_RX)
        begin
            if (rx_pos == 0)
            begin
                rx_hdr_len = {r.data[3:0], 2'b00};
                if (r.data[3:0] < MIN_IHL)
                    rx_match = 1'b0;
            end
            if (rx_pos == 9 && r.data != PROTO_TCP)
                rx_match = 1'b0;
            if (rx_pos >= 12 && rx_pos <= 15)
                src_capture = {src_capture[23:0], r.data};
            if (rx_pos >= 16 && rx_pos <= 19)
            begin
                idx = 19 - int'(rx_pos);
                if (r.data != local_addr[8*idx +: 8])
                    rx_match = 1'b0;
            end
            if (rx_match && rx_pos >= 19 && rx_pos + 17'd1 == rx_hdr_len)
                peer_addr = src_capture;
            if (rx_match && rx_pos >= HDR_BYTES && rx_pos >= rx_hdr_len)
                queue_result(PATH_RX, r.data, 1'b1, r.is_last, STATUS_OK);
            else if (r.is_last)
            begin
                if (rx_pos < 19 || !rx_match)
                    status = STATUS_DROP;
                else if (rx_pos + 17'd1 < rx_hdr_len)
                    status = STATUS_HDR_LONG;
                else
                    status = STATUS_OK;
                queue_result(PATH_RX, 8'h00, 1'b0, 1'b1, status);
            end
            if (r.is_last)
            begin
                rx_pos     = '0;
                rx_hdr_len = '0;
                rx_match   = 1'b1;
            end
            else if (rx_pos != POS_MAX)
                rx_pos++;
        end
        else
        begin
            if (tx_pos == 0)
            begin
                total = 16'd20 + r.seg_len;
                foreach (hdr[i])
                    hdr[i] = 8'h00;
                hdr[0] = VER_IHL;
                hdr[2] = total[15:8];
                hdr[3] = total[7:0];
                hdr[6] = FLAGS_DF_HI;
                hdr[8] = TTL_MAX;
                hdr[9] = PROTO_TCP;
                for (int i = 0; i < 4; i++)
                begin
                    hdr[12 + i] = local_addr[31 - 8*i -: 8];
                    hdr[16 + i] = peer_addr[31 - 8*i -: 8];
                end
                sum = '0;
                for (int i = 0; i < 20; i += 2)
                    sum = csum_add(sum, {hdr[i], hdr[i + 1]});
                sum = ~sum;
                hdr[10] = sum[15:8];
                hdr[11] = sum[7:0];
                // pseudo-header: addresses, protocol and tcp length
                sum = r.partial;
                for (int i = 12; i < 20; i += 2)
                    sum = csum_add(sum, {hdr[i], hdr[i + 1]});
                sum = csum_add(sum, {8'h00, PROTO_TCP});
                sum = csum_add(sum, r.seg_len);
                tx_csum = ~sum;
                for (int i = 0; i < 20; i++)
                    queue_result(PATH_TX, hdr[i], 1'b1, 1'b0, STATUS_OK);
            end
            ob = r.data;
            if (tx_pos == 16)
                ob = tx_csum[15:8];
            else if (tx_pos == 17)
                ob = tx_csum[7:0];
            queue_result(PATH_TX, ob, 1'b1, r.is_last, STATUS_OK);
            if (r.is_last)
                tx_pos = '0;
            else if (tx_pos != POS_MAX)
                tx_pos++;
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            fail_count++;
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        end
    endfunction

    // scoreboard and output stalls
    always @(posedge clk)
    begin
        frame_byte_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_bytes.size() == 0)
            begin
                fail_count++;
                $error("out_byte: expected nothing, actual 0x%0h", m_axis_tdata[7:0]);
            end
            else
            begin
                e = expected_bytes.pop_front();
                check_field("out_path", e.path, m_axis_tuser[0]);
                check_field("out_byte", e.data, m_axis_tdata[7:0]);
                check_field("byte_valid", e.vld, m_axis_tuser[1]);
                check_field("out_last", e.is_last, m_axis_tlast);
                check_field("packet_status", e.status, m_axis_tdata[9:8]);
            end
        end
        m_axis_tready <= no_idle || ($urandom_range(99) >= 26);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_item(input seg_req_t r);
        while (!no_idle && $urandom_range(99) < 26)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r.partial, r.seg_len, r.data};
        s_axis_tlast  <= r.is_last;
        s_axis_tuser  <= r.cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_outputs(r);
        sent_items++;
    endtask

    // sends the pending receive packet and transmit segment, mixed at random
    task automatic send_streams();
        seg_req_t r;
        while (rx_pkt.size() + tx_seg.size() != 0)
        begin
            if (tx_seg.size() == 0 || (rx_pkt.size() != 0 && $urandom_range(1) == 0))
                r = rx_pkt.pop_front();
            else
                r = tx_seg.pop_front();
            send_item(r);
        end
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_local(input bit [31:0] addr);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= addr;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        local_addr = addr;
    endtask

    task automatic build_rx(input int len, input bit [3:0] ihl, input bit [7:0] proto,
                            input bit [31:0] dst_addr, input bit [31:0] src_addr);
        seg_req_t r;
        for (int i = 0; i < len; i++)
        begin
            r.cmd     = CMD_RX;
            r.data    = 8'($urandom_range(255));
            r.is_last = (i == len - 1);
            r.seg_len = 16'($urandom);
            r.partial = 16'($urandom);
            if (i == 0)
                r.data[3:0] = ihl;
            else if (i == 9)
                r.data = proto;
            else if (i >= 12 && i <= 15)
                r.data = src_addr[8*(15 - i) +: 8];
            else if (i >= 16 && i <= 19)
                r.data = dst_addr[8*(19 - i) +: 8];
            rx_pkt.push_back(r);
        end
    endtask

    task automatic build_tx(input int len, input bit [15:0] seg_len, input bit [15:0] partial,
                            input bit use_fill, input bit [7:0] fill);
        seg_req_t r;
        for (int i = 0; i < len; i++)
        begin
            r.cmd     = CMD_TX;
            r.data    = use_fill ? fill : 8'($urandom_range(255));
            r.is_last = (i == len - 1);
            // only sampled on the first byte
            r.seg_len = (i == 0) ? seg_len : 16'($urandom);
            r.partial = (i == 0) ? partial : 16'($urandom);
            tx_seg.push_back(r);
        end
    endtask

    task automatic random_rx_packet();
        int        kind;
        int        len;
        bit [3:0]  ihl;
        bit [7:0]  proto;
        bit [31:0] dst;
        kind  = int'($urandom_range(19));
        ihl   = 4'($urandom_range(7, 5));
        proto = PROTO_TCP;
        dst   = local_addr;
        len   = int'(ihl) * 4 + int'($urandom_range(12));
        if (kind == 15)
            len = int'($urandom_range(19, 1));
        else if (kind == 16)
        begin
            proto = 8'($urandom_range(255));
            if (proto == PROTO_TCP)
                proto = ~proto;
        end
        else if (kind == 17)
            dst = dst ^ (32'h1 << $urandom_range(31));
        else if (kind == 18)
            ihl = 4'($urandom_range(4));
        else if (kind == 19)
        begin
            ihl = 4'($urandom_range(15, 6));
            len = int'($urandom_range(int'(ihl) * 4 - 1, 20));
        end
        build_rx(len, ihl, proto, dst, $urandom);
    endtask

    task automatic random_tx_segment();
        int len;
        len = ($urandom_range(7) == 0) ? int'($urandom_range(40, 1))
                                       : int'($urandom_range(24, 1));
        build_tx(len, 16'($urandom_range(65515)), 16'($urandom), 1'b0, 8'h00);
    endtask

    // address held at its reset value
    task automatic test_reset_address();
        build_rx(21, 4'h5, PROTO_TCP, 32'h0, $urandom);
        send_streams();
        build_tx(2, 16'($urandom_range(65515)), 16'($urandom), 1'b0, 8'h00);
        send_streams();
        settle();
    endtask

    task automatic test_transmit_extremes();
        write_local(32'hFFFF_FFFF);
        build_tx(1, 16'd0, 16'h0000, 1'b1, 8'h00);
        send_streams();
        // ends on the low checksum byte
        build_tx(18, 16'd65515, 16'hFFFF, 1'b1, 8'hFF);
        send_streams();
        settle();
    endtask

    task automatic test_receive_filter();
        bit [31:0] addr;
        addr = $urandom;
        write_local(addr);
        build_rx(1, 4'h5, PROTO_TCP, addr, $urandom);        // single byte
        send_streams();
        build_rx(21, 4'h5, 8'h11, addr, $urandom);           // not tcp
        send_streams();
        build_rx(22, 4'h6, PROTO_TCP, addr, $urandom);       // header longer than packet
        send_streams();
        build_rx(25, 4'h6, PROTO_TCP, addr, $urandom);       // options then payload
        send_streams();
        build_tx(18, 16'($urandom_range(65515)), 16'($urandom), 1'b0, 8'h00);
        send_streams();
        settle();
    endtask

    task automatic test_random_traffic(input bit [31:0] addr, input bit quiet);
        int start;
        write_local(addr);
        no_idle = quiet;
        start   = sent_items;
        while (sent_items - start < 20)
        begin
            if ($urandom_range(99) < 65)
                random_rx_packet();
            if (rx_pkt.size() == 0 || $urandom_range(99) < 50)
                random_tx_segment();
            send_streams();
        end
        settle();
        no_idle = 1'b0;
    endtask

    initial
    begin
        reset_model();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_address();
        test_transmit_extremes();
        test_receive_filter();
        test_random_traffic($urandom, 1'b1);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
